/* rtl/core/xoshiro256_starstar_generator_macros.svh */
// Assertion macros shared by the generator RTL.
`ifndef XOSHIRO256_STARSTAR_GENERATOR_MACROS_SVH
`define XOSHIRO256_STARSTAR_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define XSS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define XSS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/xss_pkg.sv */
// Types, constants and step functions for the xoshiro256** generator.
package xss_pkg;

	typedef enum logic [1:0] {
		CMD_NEXT      = 2'd0,
		CMD_JUMP      = 2'd1,
		CMD_LONG_JUMP = 2'd2,
		CMD_LOAD      = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCRAMBLE,
		ST_EMIT_NEXT,
		ST_JUMP,
		ST_JUMP_END,
		ST_EMIT
	} xss_state_t;

	typedef logic [3:0][63:0] gen_state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [1:0]  word_index;
		logic [63:0] load_value;
	} cmd_beat_t;

	typedef struct packed {
		logic [63:0] random_value;
		logic        value_valid;
	} result_beat_t;

	// Jump polynomials, word 3 in the top bits: bit w*64+b is bit b of word w.
	localparam logic [255:0] JUMP_POLY = {
		64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
		64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
	};
	localparam logic [255:0] LONG_JUMP_POLY = {
		64'h39109bb02acbe635, 64'h77710069854ee241,
		64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
	};

	localparam int unsigned SHIFT_B   = 17;
	localparam int unsigned ROT_C     = 45;
	localparam int unsigned ROT_OUT   = 7;
	localparam int unsigned MUL5_SHL  = 2; // x*5 = x + (x << 2)
	localparam int unsigned MUL9_SHL  = 3; // x*9 = x + (x << 3)

	function automatic logic [63:0] rotl64(logic [63:0] x, int unsigned k);
		return (x << k) | (x >> (64 - k));
	endfunction

	function automatic logic poly_bit(logic long_sel, logic [7:0] idx);
		return long_sel ? LONG_JUMP_POLY[idx] : JUMP_POLY[idx];
	endfunction

	// One xor/shift/rotate state update.
	function automatic gen_state_t xss_advance(gen_state_t s);
		gen_state_t n;
		n[2] = s[2] ^ s[0];
		n[3] = s[3] ^ s[1];
		n[1] = s[1] ^ n[2];
		n[0] = s[0] ^ n[3];
		n[2] = n[2] ^ (s[1] << SHIFT_B);
		n[3] = rotl64(n[3], ROT_C);
		return n;
	endfunction

endpackage

/* rtl/core/xss_stream_if.sv */
// Valid/ready stream channel carrying one payload beat.
interface xss_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

/* rtl/core/xoshiro256_starstar_generator.sv */
// xoshiro256** generator top level: command channel in, result channel out.
//
// xoshiro256** pseudo-random generator, 256 bits of state in four 64-bit words
// that reset to 1, 2, 3, 4. Every command beat on in_ch yields exactly one
// result beat on out_ch. A next command returns rotl(s1*5,7)*9 with
// value_valid set and advances the state; its result passes through the
// scramble and emit states, because the two constant multiplies run one after
// the other through a single shared 64-bit shift-add unit. Jump and long jump
// walk their 256-bit polynomial one bit per clock, then load the accumulator
// into the state in the jump end state before the result is written. Load
// writes one state word and answers from the emit state. Jump, long jump and
// load return zero with value_valid clear. One command is in flight at a
// time: in_ch.ready is high only while the sequencer is idle. The result sits
// in an output register, so a new command is taken while an earlier result
// still waits on out_ch; the sequencer only stalls if it must write a result
// and that register is full. An all-zero state is not guarded against and
// stays at zero.
`include "xoshiro256_starstar_generator_macros.svh"

module xoshiro256_starstar_generator (
	input  logic          clk,
	input  logic          arst_n,
	xss_stream_if.sink    in_ch,
	xss_stream_if.source  out_ch
);
	import xss_pkg::*;

	xss_state_t   state_q, state_d;
	gen_state_t   s_q;      // generator state
	gen_state_t   acc_q;    // jump accumulator
	logic [7:0]   cnt_q;    // polynomial bit position
	logic         long_q;   // long jump polynomial selected
	logic [63:0]  t_q;      // s1*5 held between the two multiplies
	logic         out_valid_q;
	result_beat_t out_q;

	logic         in_take;
	logic         slot_free;
	logic         emit;       // write the output register this cycle
	logic         emit_rand;  // written beat carries a generated number

	// Shared shift-add unit: sum = x + (x << sh), i.e. x*5 or x*9.
	logic [63:0]  add_x;
	logic [63:0]  add_sum;
	logic         add_mul9;

	assign in_take   = in_ch.valid && in_ch.ready;
	assign slot_free = !out_valid_q || out_ch.ready;

	assign add_x   = add_mul9 ? rotl64(t_q, ROT_OUT) : s_q[1];
	assign add_sum = add_x + (add_mul9 ? (add_x << MUL9_SHL) : (add_x << MUL5_SHL));

	// Sequencer: next state and per-cycle controls.
	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		emit        = 1'b0;
		emit_rand   = 1'b0;
		add_mul9    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					case (in_ch.payload.command)
						CMD_NEXT:      state_d = ST_SCRAMBLE;
						CMD_JUMP:      state_d = ST_JUMP;
						CMD_LONG_JUMP: state_d = ST_JUMP;
						default:       state_d = ST_EMIT;
					endcase
				end
			end
			ST_SCRAMBLE: begin
				state_d = ST_EMIT_NEXT;
			end
			ST_EMIT_NEXT: begin
				add_mul9 = 1'b1;
				if (slot_free) begin
					emit      = 1'b1;
					emit_rand = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_JUMP: begin
				if (cnt_q == 8'hff) begin
					state_d = ST_JUMP_END;
				end
			end
			ST_JUMP_END: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Generator state, jump walk and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q    <= {64'd4, 64'd3, 64'd2, 64'd1};
			cnt_q  <= 8'd0;
			long_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						long_q <= (in_ch.payload.command == CMD_LONG_JUMP);
						if (in_ch.payload.command == CMD_LOAD) begin
							s_q[in_ch.payload.word_index] <= in_ch.payload.load_value;
						end
					end
				end
				ST_SCRAMBLE: begin
					// s1 is consumed by the adder this cycle, so step now
					s_q <= xss_advance(s_q);
				end
				ST_JUMP: begin
					s_q   <= xss_advance(s_q);
					cnt_q <= cnt_q + 8'd1;
				end
				ST_JUMP_END: begin
					s_q <= acc_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (in_take) begin
			acc_q <= '0;
		end else if (state_q == ST_JUMP && poly_bit(long_q, cnt_q)) begin
			acc_q <= acc_q ^ s_q;
		end
		if (state_q == ST_SCRAMBLE) begin
			t_q <= add_sum;
		end
		if (emit) begin
			out_q.random_value <= emit_rand ? add_sum : 64'd0;
			out_q.value_valid  <= emit_rand;
		end
	end

	// Output register: one beat, held until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;

	`XSS_ASSERT_NXT(a_next_scrambles, in_take && in_ch.payload.command == CMD_NEXT, state_q == ST_SCRAMBLE, "next command did not start the scramble")
	`XSS_ASSERT_IMP(a_cnt_idle, state_q != ST_JUMP, cnt_q == 8'd0, "jump counter moved outside a jump")
	`XSS_ASSERT_NXT(a_load_writes, in_take && in_ch.payload.command == CMD_LOAD, s_q[$past(in_ch.payload.word_index)] == $past(in_ch.payload.load_value), "load did not write the state word")
	`XSS_ASSERT_IMP(a_zero_when_invalid, out_ch.valid && !out_ch.payload.value_valid, out_ch.payload.random_value == 64'd0, "non-next result carries a value")

endmodule
